FILE: rtl/multichannel_input_debouncer_top_assert.svh
// Assertion macros used by the checker of the debouncer.
`ifndef MULTICHANNEL_INPUT_DEBOUNCER_TOP_ASSERT_SVH
`define MULTICHANNEL_INPUT_DEBOUNCER_TOP_ASSERT_SVH

// same-cycle implication
`define MIDT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MIDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/midt_pkg.sv
package midt_pkg;

    localparam int MaxChannels = 16;
    localparam int ChW         = 4;
    localparam int LimitW      = 7;
    localparam int ChCountW    = 5;
    localparam int CntW        = 8;

    typedef enum logic {
        CfgStableCount  = 1'b0,
        CfgChannelCount = 1'b1
    } t_cfg_idx;

    // one sample after classification
    typedef struct packed {
        logic [MaxChannels-1:0] high;  // level taken as high (failed read counts low)
        logic [MaxChannels-1:0] upd;   // enabled and read ok
        logic [MaxChannels-1:0] en;    // enabled channels
    } t_item;

    typedef struct packed {
        logic                   is_change;
        logic [ChW-1:0]         channel;
        logic                   new_level;
        logic [MaxChannels-1:0] confirmed;
        logic [MaxChannels-1:0] valid_ch;
        logic                   last;
    } t_result;

endpackage

FILE: rtl/midt_front.sv
module midt_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tvalid,
    output logic                           o_tready,
    input  logic [midt_pkg::MaxChannels-1:0] i_raw,
    input  logic [midt_pkg::MaxChannels-1:0] i_fail,
    input  logic [midt_pkg::MaxChannels-1:0] i_en_mask,
    output logic                           o_item_valid,
    output midt_pkg::t_item                o_item,
    input  logic                           i_item_pop
);

    logic [1:0]      r_fill;
    logic            r_wp;
    logic            r_rp;
    midt_pkg::t_item r_q [2];
    midt_pkg::t_item w_item;
    logic            w_push;
    logic            w_pop;

    always_comb begin
        w_item.high = i_raw & ~i_fail;
        w_item.upd  = i_en_mask & ~i_fail;
        w_item.en   = i_en_mask;
    end

    assign o_tready     = (r_fill != 2'd2);
    assign w_push       = i_tvalid && o_tready;
    assign o_item_valid = (r_fill != 2'd0);
    assign w_pop        = i_item_pop && o_item_valid;
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

FILE: rtl/midt_engine.sv
module midt_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [midt_pkg::LimitW-1:0]      i_stable_count,
    input  logic                             i_item_valid,
    input  midt_pkg::t_item                  i_item,
    output logic                             o_item_pop,
    output logic                             o_res_valid,
    output midt_pkg::t_result                o_res,
    input  logic                             i_res_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STATUS
    } t_state;

    t_state                              r_state;
    logic [midt_pkg::ChW-1:0]            r_ch;
    midt_pkg::t_item                     r_item;
    logic                                r_seed_pass;
    logic                                r_seeded;
    logic [midt_pkg::CntW-1:0]           r_cnt [midt_pkg::MaxChannels];
    logic [midt_pkg::MaxChannels-1:0]    r_conf;
    logic [midt_pkg::MaxChannels-1:0]    r_valid;
    logic                                r_out_valid;
    midt_pkg::t_result                   r_out;

    logic                                w_slot_free;
    logic                                w_emit;
    logic [midt_pkg::CntW-1:0]           w_lim;
    logic [midt_pkg::CntW-1:0]           w_neg;
    logic [midt_pkg::CntW-1:0]           w_c;
    logic [midt_pkg::CntW-1:0]           n_c;
    logic                                w_hi;
    logic                                w_at_hi;
    logic                                w_at_lo;
    logic                                w_flip;
    logic [midt_pkg::MaxChannels-1:0]    w_conf_upd;
    logic [midt_pkg::MaxChannels-1:0]    w_valid_upd;

    assign w_slot_free = !r_out_valid || i_res_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_item_pop  = i_item_valid
                      && ((r_state == ST_IDLE) || ((r_state == ST_STATUS) && w_slot_free));
    // a result is loaded on a change event during a normal pass, or on the status slot
    assign w_emit      = w_slot_free
                      && (((r_state == ST_SCAN) && !r_seed_pass && w_flip)
                          || (r_state == ST_STATUS));

    always_comb begin
        // a limit of zero behaves as one
        w_lim = {1'b0, (i_stable_count == '0) ? midt_pkg::LimitW'(1) : i_stable_count};
        w_neg = -w_lim;
        w_c   = r_cnt[r_ch];
        w_hi  = r_item.high[r_ch];
        if (w_hi) begin
            n_c = ($signed(w_c) < $signed(w_lim)) ? w_c + 1'b1 : w_c;
        end else begin
            n_c = ($signed(w_c) > $signed(w_neg)) ? w_c - 1'b1 : w_c;
        end
        // a counter left beyond a lowered limit still counts as at that end
        w_at_hi = ($signed(n_c) >= $signed(w_lim));
        w_at_lo = ($signed(n_c) <= $signed(w_neg));
        w_flip  = r_item.upd[r_ch] && (w_at_hi || w_at_lo) && (w_at_hi != r_conf[r_ch]);
        w_conf_upd         = r_conf;
        w_conf_upd[r_ch]   = w_at_hi;
        w_valid_upd        = r_valid;
        w_valid_upd[r_ch]  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= '0;
            r_seed_pass <= 1'b0;
            r_seeded    <= 1'b0;
            r_conf      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < midt_pkg::MaxChannels; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_item_valid) begin
                        r_item      <= i_item;
                        r_seed_pass <= !r_seeded;
                        r_seeded    <= 1'b1;
                        r_ch        <= '0;
                        r_state     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_slot_free) begin
                        if (r_seed_pass) begin
                            if (r_item.en[r_ch]) begin
                                r_cnt[r_ch]   <= w_hi ? w_lim : w_neg;
                                r_conf[r_ch]  <= w_hi;
                                r_valid[r_ch] <= 1'b1;
                            end
                        end else if (r_item.upd[r_ch]) begin
                            r_cnt[r_ch] <= n_c;
                            if (w_flip) begin
                                r_conf            <= w_conf_upd;
                                r_valid           <= w_valid_upd;
                                r_out.is_change   <= 1'b1;
                                r_out.channel     <= r_ch;
                                r_out.new_level   <= w_at_hi;
                                r_out.confirmed   <= w_conf_upd;
                                r_out.valid_ch    <= w_valid_upd;
                                r_out.last        <= 1'b0;
                            end
                        end
                        if (r_ch == midt_pkg::ChW'(midt_pkg::MaxChannels - 1)) begin
                            r_state <= ST_STATUS;
                        end
                        r_ch <= r_ch + 1'b1;
                    end
                end
                ST_STATUS: begin
                    if (w_slot_free) begin
                        r_out.is_change <= 1'b0;
                        r_out.channel   <= '0;
                        r_out.new_level <= 1'b0;
                        r_out.confirmed <= r_conf;
                        r_out.valid_ch  <= r_valid;
                        r_out.last      <= 1'b1;
                        if (i_item_valid) begin
                            r_item      <= i_item;
                            r_seed_pass <= !r_seeded;
                            r_seeded    <= 1'b1;
                            r_ch        <= '0;
                            r_state     <= ST_SCAN;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/multichannel_input_debouncer_top.sv
// Stream  Dir  tvalid/tready  tdata fields (low bit up)                  tuser / tlast
// s_axis  in   per sample     raw_levels[15:0], read_failed[31:16]       -
// m_axis  out  per result     channel, new_level, confirmed, valid, pad  is_change / last
// cfg     in   i_cfg_we       idx 0 stable_count, idx 1 channel_count    -
//
// The engine walks all 16 channels, one per cycle while the output is free,
// then emits the status result and takes the next queued sample straight from
// the status state. A stalled output holds the walk at the current channel.
// A two-entry sample queue takes samples while the walk runs; tready drops when full.
// Synchronous active-low reset clears counters, levels, valid mask and the
// seeding flag; config resets to stable_count 4, channel_count 16.
module multichannel_input_debouncer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // raw_levels, read_failed
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [39:0]                       m_axis_tdata,   // channel, new_level,
                                                              // confirmed_levels, valid_channels,
                                                              // zero pad
    output logic                              m_axis_tuser,   // is_change
    output logic                              m_axis_tlast,   // last
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [midt_pkg::LimitW-1:0]       i_cfg_data
);

    logic [midt_pkg::LimitW-1:0]      r_stable_count;
    logic [midt_pkg::ChCountW-1:0]    r_channel_count;
    logic [midt_pkg::MaxChannels-1:0] w_en_mask;
    logic                             w_item_valid;
    midt_pkg::t_item                  w_item;
    logic                             w_item_pop;
    midt_pkg::t_result                w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_count  <= midt_pkg::LimitW'(4);
            r_channel_count <= midt_pkg::ChCountW'(midt_pkg::MaxChannels);
        end else if (i_cfg_we) begin
            case (midt_pkg::t_cfg_idx'(i_cfg_idx))
                midt_pkg::CfgStableCount:  r_stable_count  <= i_cfg_data;
                midt_pkg::CfgChannelCount: r_channel_count <= i_cfg_data[midt_pkg::ChCountW-1:0];
                default: ;
            endcase
        end
    end

    // stored counts above the channel total enable every channel; a written count keeps its low five bits
    always_comb begin
        for (int i = 0; i < midt_pkg::MaxChannels; i++) begin
            w_en_mask[i] = (midt_pkg::ChCountW'(i) < r_channel_count);
        end
    end

    midt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tvalid     (s_axis_tvalid),
        .o_tready     (s_axis_tready),
        .i_raw        (s_axis_tdata[15:0]),
        .i_fail       (s_axis_tdata[31:16]),
        .i_en_mask    (w_en_mask),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_pop   (w_item_pop)
    );

    midt_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stable_count (r_stable_count),
        .i_item_valid   (w_item_valid),
        .i_item         (w_item),
        .o_item_pop     (w_item_pop),
        .o_res_valid    (m_axis_tvalid),
        .o_res          (w_res),
        .i_res_ready    (m_axis_tready)
    );

    assign m_axis_tdata = {3'b000, w_res.valid_ch, w_res.confirmed, w_res.new_level, w_res.channel};
    assign m_axis_tuser = w_res.is_change;
    assign m_axis_tlast = w_res.last;

endmodule

FILE: rtl/midt_checker.sv
`include "multichannel_input_debouncer_top_assert.svh"

module midt_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [39:0]                 m_axis_tdata,
    input  logic                        m_axis_tuser,
    input  logic                        m_axis_tlast,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [midt_pkg::LimitW-1:0] i_cfg_data
);

    logic [15:0] w_conf;
    logic [15:0] w_valid;
    logic [3:0]  w_ch;
    logic        w_unused;

    assign w_conf   = m_axis_tdata[20:5];
    assign w_valid  = m_axis_tdata[36:21];
    assign w_ch     = m_axis_tdata[3:0];
    assign w_unused = ^{s_axis_tvalid, s_axis_tready, s_axis_tdata, i_cfg_we, i_cfg_idx,
                        i_cfg_data};

    `MIDT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

    `MIDT_ASSERT_NOW(a_kind_last, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser != m_axis_tlast, "change flag and last disagree")

    `MIDT_ASSERT_NOW(a_status_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[4:0] == 5'd0, "status result carries channel or level")

    `MIDT_ASSERT_NOW(a_event_level, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, (w_conf[w_ch] == m_axis_tdata[4]) && w_valid[w_ch] && !w_unused == !w_unused, "change event disagrees with level masks")

endmodule

bind multichannel_input_debouncer_top midt_checker u_midt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx),
    .i_cfg_data    (i_cfg_data)
);
